>>> sv/lae_pkg.sv
// shared types and constants for the linear adsr envelope unit
`timescale 1ns / 1ps

package lae_pkg;

    localparam int DATA_W    = 24;
    localparam int CFG_IDX_W = 2;

    // item function codes
    localparam logic [1:0] FUNC_SAMPLE  = 2'd0;
    localparam logic [1:0] FUNC_RELEASE = 2'd1;
    localparam logic [1:0] FUNC_START   = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ATTACK  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DECAY   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SUSTAIN = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RELEASE = 2'd3;

    localparam logic [DATA_W-1:0] ATTACK_RST  = 24'd4800;
    localparam logic [DATA_W-1:0] DECAY_RST   = 24'd4800;
    localparam logic [DATA_W-1:0] SUSTAIN_RST = 24'd4194304;
    localparam logic [DATA_W-1:0] RELEASE_RST = 24'd4800;
    localparam logic [DATA_W-1:0] SUSTAIN_MAX = 24'd8388608;

    typedef enum logic [2:0] {
        PH_ATTACK,
        PH_DECAY,
        PH_SUSTAIN,
        PH_RELEASE,
        PH_COMPLETE
    } env_phase_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_ADV_COUNT,
        ST_ADV_CHECK,
        ST_DIV,
        ST_UPDATE,
        ST_EMIT
    } ctl_state_t;

    typedef struct packed {
        logic [1:0]               func;
        logic signed [DATA_W-1:0] sample_in;
        logic                     buffer_end_in;
    } in_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] sample_out;
        logic                     complete;
        logic                     buffer_end_out;
    } out_item_t;

    // a length of zero counts as one
    function automatic logic [DATA_W-1:0] eff_len(input logic [DATA_W-1:0] v);
        return (v == '0) ? DATA_W'(1) : v;
    endfunction

endpackage

>>> sv/linear_adsr_envelope_unit.sv
// linear adsr envelope unit: bit-serial sample scaling and step division
// a sample item runs through the serial multiply, the count advance, the phase check and the
//   level update (skipped once the envelope completes); a phase change may add a step divide
// one item at a time: in_ready is high only in idle; a release request is taken in idle, a start
//   item runs the step divide; the serial multiply and divide work one bit per cycle
// reset: envelope complete at zero level, configuration registers at their default values
`timescale 1ns / 1ps

module linear_adsr_envelope_unit #(
    parameter int COUNT_WIDTH = 32,
    parameter int FRAC_BITS   = 30
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  lae_pkg::in_item_t                    in_data,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output lae_pkg::out_item_t                   out_data,
    input  logic                                 cfg_we,
    input  logic [lae_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [lae_pkg::DATA_W-1:0]           cfg_data
);
    import lae_pkg::*;

    localparam int LVL_W     = FRAC_BITS + 1;
    localparam int STEP_W    = FRAC_BITS + 2;
    localparam int SUM_W     = FRAC_BITS + 3;
    localparam int CNT_W     = $clog2(FRAC_BITS + 1);
    localparam int SUS_SHIFT = 30 - FRAC_BITS;
    localparam logic [LVL_W-1:0] ONE_LEVEL = {1'b1, {FRAC_BITS{1'b0}}};

    // control and envelope state
    ctl_state_t              state_reg, state_next;
    env_phase_t              phase_reg, phase_next;
    logic [COUNT_WIDTH-1:0]  count_reg, count_next;
    logic [COUNT_WIDTH-1:0]  phase_end_reg, phase_end_next;
    logic                    hold_reg, hold_next;
    logic [LVL_W-1:0]        level_reg, level_next;
    logic [STEP_W-1:0]       step_reg, step_next;
    logic [DATA_W-1:0]       attack_reg, attack_next;
    logic [DATA_W-1:0]       decay_reg, decay_next;
    logic [DATA_W-1:0]       sustain_reg, sustain_next;
    logic [DATA_W-1:0]       release_reg, release_next;
    logic                    out_valid_reg, out_valid_next;
    logic                    is_sample_reg, is_sample_next;
    logic                    div_adv_reg, div_adv_next;
    logic [CNT_W-1:0]        bit_cnt_reg, bit_cnt_next;

    // datapath registers
    logic [DATA_W-1:0]       sample_reg, sample_next;
    logic                    buf_end_reg, buf_end_next;
    logic [LVL_W-1:0]        mul_lvl_reg, mul_lvl_next;
    logic [DATA_W:0]         acc_hi_reg, acc_hi_next;
    logic [LVL_W-1:0]        acc_lo_reg, acc_lo_next;
    logic [LVL_W-1:0]        div_q_reg, div_q_next;
    logic [DATA_W-1:0]       div_rem_reg, div_rem_next;
    logic [DATA_W-1:0]       div_den_reg, div_den_next;
    logic                    div_neg_reg, div_neg_next;
    out_item_t               out_reg, out_next;

    // combinational helpers
    logic [DATA_W-1:0]       sus_clamp;
    logic [30:0]             sus_wide;
    logic [LVL_W-1:0]        sus_fix;
    logic [DATA_W+1:0]       mul_sum;
    logic [DATA_W:0]         rem_sh;
    logic                    div_ge;
    logic [DATA_W:0]         rem_diff;
    logic [SUM_W-1:0]        lvl_sum;
    logic                    out_free;

    always_comb
    begin
        sus_clamp = (sustain_reg > SUSTAIN_MAX) ? SUSTAIN_MAX : sustain_reg;
        sus_wide  = {sus_clamp, 7'b0} >> SUS_SHIFT;
        sus_fix   = sus_wide[FRAC_BITS:0];

        // shift-add multiply, multiplier bit lsb first
        mul_sum = {acc_hi_reg[DATA_W], acc_hi_reg}
                + (mul_lvl_reg[0] ? {{2{sample_reg[DATA_W-1]}}, sample_reg} : '0);

        // restoring divide, one quotient bit per cycle
        rem_sh   = {div_rem_reg, div_q_reg[LVL_W-1]};
        div_ge   = (rem_sh >= {1'b0, div_den_reg});
        rem_diff = rem_sh - {1'b0, div_den_reg};

        lvl_sum  = {2'b00, level_reg} + {step_reg[STEP_W-1], step_reg};
        out_free = !out_valid_reg || out_ready;
    end

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        count_next     = count_reg;
        phase_end_next = phase_end_reg;
        hold_next      = hold_reg;
        level_next     = level_reg;
        step_next      = step_reg;
        attack_next    = attack_reg;
        decay_next     = decay_reg;
        sustain_next   = sustain_reg;
        release_next   = release_reg;
        out_valid_next = out_valid_reg;
        is_sample_next = is_sample_reg;
        div_adv_next   = div_adv_reg;
        bit_cnt_next   = bit_cnt_reg;
        sample_next    = sample_reg;
        buf_end_next   = buf_end_reg;
        mul_lvl_next   = mul_lvl_reg;
        acc_hi_next    = acc_hi_reg;
        acc_lo_next    = acc_lo_reg;
        div_q_next     = div_q_reg;
        div_rem_next   = div_rem_reg;
        div_den_next   = div_den_reg;
        div_neg_next   = div_neg_reg;
        out_next       = out_reg;
        in_ready       = (state_reg == ST_IDLE);

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg_we)
        begin
            case (cfg_index)
                REG_ATTACK:  attack_next  = cfg_data;
                REG_DECAY:   decay_next   = cfg_data;
                REG_SUSTAIN: sustain_next = cfg_data;
                REG_RELEASE: release_next = cfg_data;
                default:     attack_next  = attack_reg;
            endcase
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    sample_next  = in_data.sample_in;
                    buf_end_next = in_data.buffer_end_in;
                    bit_cnt_next = CNT_W'(FRAC_BITS);
                    case (in_data.func)
                        FUNC_SAMPLE:
                        begin
                            is_sample_next = 1'b1;
                            mul_lvl_next   = level_reg;
                            acc_hi_next    = '0;
                            acc_lo_next    = '0;
                            state_next     = ST_MUL;
                        end
                        FUNC_RELEASE:
                        begin
                            phase_next     = PH_SUSTAIN;
                            phase_end_next = count_reg;
                            hold_next      = 1'b0;
                        end
                        FUNC_START:
                        begin
                            is_sample_next = 1'b0;
                            phase_next     = PH_ATTACK;
                            count_next     = '0;
                            phase_end_next = COUNT_WIDTH'(eff_len(attack_reg));
                            hold_next      = 1'b0;
                            level_next     = '0;
                            div_q_next     = ONE_LEVEL;
                            div_rem_next   = '0;
                            div_den_next   = eff_len(attack_reg);
                            div_neg_next   = 1'b0;
                            div_adv_next   = 1'b1;
                            state_next     = ST_DIV;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end

            ST_MUL:
            begin
                acc_hi_next  = mul_sum[DATA_W+1:1];
                acc_lo_next  = {mul_sum[0], acc_lo_reg[LVL_W-1:1]};
                mul_lvl_next = mul_lvl_reg >> 1;
                bit_cnt_next = bit_cnt_reg - 1'b1;
                if (bit_cnt_reg == '0)
                begin
                    state_next = ST_ADV_COUNT;
                end
            end

            ST_ADV_COUNT:
            begin
                count_next = count_reg + 1'b1;
                state_next = (phase_reg == PH_COMPLETE) ? (is_sample_reg ? ST_EMIT : ST_IDLE)
                                                        : ST_ADV_CHECK;
            end

            ST_ADV_CHECK:
            begin
                state_next   = ST_UPDATE;
                bit_cnt_next = CNT_W'(FRAC_BITS);
                div_rem_next = '0;
                div_adv_next = 1'b0;
                if (!hold_reg && (count_reg > phase_end_reg))
                begin
                    case (phase_reg)
                        PH_ATTACK:
                        begin
                            phase_next     = PH_DECAY;
                            phase_end_next = phase_end_reg
                                           + COUNT_WIDTH'(eff_len(decay_reg));
                            div_q_next     = ONE_LEVEL - sus_fix;
                            div_den_next   = eff_len(decay_reg);
                            div_neg_next   = 1'b1;
                            state_next     = ST_DIV;
                        end
                        PH_DECAY:
                        begin
                            phase_next = PH_SUSTAIN;
                            hold_next  = 1'b1;
                            level_next = sus_fix;
                            step_next  = '0;
                        end
                        PH_SUSTAIN:
                        begin
                            phase_next     = PH_RELEASE;
                            phase_end_next = phase_end_reg
                                           + COUNT_WIDTH'(eff_len(release_reg));
                            div_q_next     = level_reg;
                            div_den_next   = eff_len(release_reg);
                            div_neg_next   = 1'b1;
                            state_next     = ST_DIV;
                        end
                        default:
                        begin
                            // release runs out: no level update after this
                            phase_next = PH_COMPLETE;
                            level_next = '0;
                            step_next  = '0;
                            state_next = is_sample_reg ? ST_EMIT : ST_IDLE;
                        end
                    endcase
                end
            end

            ST_DIV:
            begin
                div_q_next   = {div_q_reg[LVL_W-2:0], div_ge};
                div_rem_next = div_ge ? rem_diff[DATA_W-1:0] : rem_sh[DATA_W-1:0];
                bit_cnt_next = bit_cnt_reg - 1'b1;
                if (bit_cnt_reg == '0)
                begin
                    step_next  = div_neg_reg ? (~{1'b0, div_q_next} + 1'b1)
                                             : {1'b0, div_q_next};
                    state_next = div_adv_reg ? ST_ADV_COUNT : ST_UPDATE;
                end
            end

            ST_UPDATE:
            begin
                if (lvl_sum[SUM_W-1])
                begin
                    level_next = '0;
                end
                else if (lvl_sum[SUM_W-2:0] > {1'b0, ONE_LEVEL})
                begin
                    level_next = ONE_LEVEL;
                end
                else
                begin
                    level_next = lvl_sum[FRAC_BITS:0];
                end
                state_next = is_sample_reg ? ST_EMIT : ST_IDLE;
            end

            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_next.sample_out     = {acc_hi_reg[DATA_W-2:0], acc_lo_reg[LVL_W-1]};
                    out_next.complete       = (phase_reg == PH_COMPLETE);
                    out_next.buffer_end_out = buf_end_reg;
                    out_valid_next          = 1'b1;
                    state_next              = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PH_COMPLETE;
            count_reg     <= '0;
            phase_end_reg <= '0;
            hold_reg      <= 1'b0;
            level_reg     <= '0;
            step_reg      <= '0;
            attack_reg    <= ATTACK_RST;
            decay_reg     <= DECAY_RST;
            sustain_reg   <= SUSTAIN_RST;
            release_reg   <= RELEASE_RST;
            out_valid_reg <= 1'b0;
            is_sample_reg <= 1'b0;
            div_adv_reg   <= 1'b0;
            bit_cnt_reg   <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            count_reg     <= count_next;
            phase_end_reg <= phase_end_next;
            hold_reg      <= hold_next;
            level_reg     <= level_next;
            step_reg      <= step_next;
            attack_reg    <= attack_next;
            decay_reg     <= decay_next;
            sustain_reg   <= sustain_next;
            release_reg   <= release_next;
            out_valid_reg <= out_valid_next;
            is_sample_reg <= is_sample_next;
            div_adv_reg   <= div_adv_next;
            bit_cnt_reg   <= bit_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg  <= sample_next;
        buf_end_reg <= buf_end_next;
        mul_lvl_reg <= mul_lvl_next;
        acc_hi_reg  <= acc_hi_next;
        acc_lo_reg  <= acc_lo_next;
        div_q_reg   <= div_q_next;
        div_rem_reg <= div_rem_next;
        div_den_reg <= div_den_next;
        div_neg_reg <= div_neg_next;
        out_reg     <= out_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    a_sample_starts_mul: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && (in_data.func == FUNC_SAMPLE)) |=> (state_reg == ST_MUL))
        else $error("sample item did not start the multiply");

    a_hold_in_sustain: assert property (@(posedge clk) disable iff (!rst_n)
        hold_reg |-> (phase_reg == PH_SUSTAIN))
        else $error("sustain hold set outside sustain");

    a_complete_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_COMPLETE) |-> ((level_reg == '0) && (step_reg == '0)))
        else $error("complete envelope with nonzero level or step");

    a_level_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        level_reg <= ONE_LEVEL)
        else $error("envelope level above unity");

    a_emit_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && out_valid_reg && !out_ready) |=> (state_reg == ST_EMIT))
        else $error("result overwrote a waiting item");

endmodule
